// ===== design/lltd_pkg.sv =====
// ----------------------------------------------------------------------------
// lltd_pkg
// shared widths, codes and parameter defaults of the least-loaded dispatcher
// ----------------------------------------------------------------------------
package lltd_pkg;

	// parameter defaults
	localparam int MAX_WORKERS_DEF = 8;
	localparam int COUNT_BITS_DEF  = 8;

	// fixed field widths
	localparam int CMD_W    = 1;
	localparam int DONE_W   = 3;
	localparam int TAG_W    = 16;
	localparam int STATUS_W = 3;
	localparam int WORKER_W = 3;
	localparam int LOAD_W   = 8;
	localparam int WIU_W    = 4;
	localparam int LIMIT_W  = 8;

	// stream payload widths, padded to whole bytes
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 32;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPATCH_LIMIT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_ROBIN_MODE = 2'd2;

	localparam logic [WIU_W-1:0] WIU_RESET = 4'd8;

	// request kinds
	localparam logic [CMD_W-1:0] CMD_DISPATCH = 1'b0;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_RETRY      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DONE_OK    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DONE_ERR   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL       = 3'd4;

endpackage

// ===== design/least_loaded_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// least_loaded_task_dispatcher
// join-shortest-queue dispatch over a pool of workers with pending counters
// ----------------------------------------------------------------------------
// usage
//  - s_* stream: one request per handshake; s_tuser says dispatch (0) or
//    completion (1), s_tdata carries the finished worker and the task tag
//  - m_* stream: exactly one result per request, status in m_tuser
//  - cfg_*: register writes (worker count, dispatch limit, round-robin mode),
//    always ready, to be written only while the block is idle
// timing
//  - a dispatch scans the workers in use through one shared compare unit fed
//    from the counter memory, one worker a cycle, set by the one read port of
//    the memory; an idle worker ends the scan early
//  - a completion reads its counter at accept and registers its result from S_CRD
//  - one request at a time; s_tready is high only while idle, until the result
//    of the previous request has been registered
// reset
//  - all counters read as zero (per-worker valid bits), pointer at worker 0,
//    registers at eight workers, no limit, round robin off
// back-pressure
//  - the result register holds while m_tready is low; a new request may still
//    be taken, and its result waits until the register frees
// ----------------------------------------------------------------------------
module least_loaded_task_dispatcher #(
	parameter int MAX_WORKERS = lltd_pkg::MAX_WORKERS_DEF,
	parameter int COUNT_BITS  = lltd_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lltd_pkg::S_DATA_W-1:0]   s_tdata,   // done_worker[2:0], task_tag[18:3]
	input  logic [lltd_pkg::CMD_W-1:0]      s_tuser,   // cmd[0]
	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [lltd_pkg::M_DATA_W-1:0]   m_tdata,   // worker[2:0], tag_out[18:3], load_after[26:19]
	output logic [lltd_pkg::STATUS_W-1:0]   m_tuser,   // status[2:0]
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lltd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lltd_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IdxW  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int NW    = $clog2(MAX_WORKERS + 1);
	// common width for worker count and index compares
	localparam int CmpW  = (NW > lltd_pkg::WIU_W) ? NW : lltd_pkg::WIU_W;
	// common width for count versus limit compares
	localparam int LimW  = (COUNT_BITS > lltd_pkg::LIMIT_W) ? COUNT_BITS : lltd_pkg::LIMIT_W;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
	localparam logic [1:0] S_CRD  = 2'd1;  // completion: count read back
	localparam logic [1:0] S_SCAN = 2'd2;  // dispatch: one worker a cycle
	localparam logic [1:0] S_DEC  = 2'd3;  // dispatch: decide and update

	logic [1:0]                      state_q;

	// configuration registers
	logic [lltd_pkg::WIU_W-1:0]      wiu_q;
	logic [lltd_pkg::LIMIT_W-1:0]    limit_q;
	logic                            rr_q;

	// scan state
	logic [IdxW-1:0]                 ptr_q;
	logic [IdxW-1:0]                 idx_q;
	logic [NW-1:0]                   iss_q;
	logic                            cmp_vld_s1;
	logic [IdxW-1:0]                 cmp_idx_s1;
	logic                            have_best_q;
	logic [IdxW-1:0]                 best_q;
	logic [COUNT_BITS-1:0]           best_cnt_q;

	// request fields held for the duration of the work
	logic [lltd_pkg::TAG_W-1:0]      tag_q;
	logic [lltd_pkg::DONE_W-1:0]     done_q;
	logic                            done_bad_q;

	// pending counter memory, valid bits make unwritten entries read zero
	logic [COUNT_BITS-1:0]           mem_q [MAX_WORKERS];
	logic [MAX_WORKERS-1:0]          vld_q;
	logic [COUNT_BITS-1:0]           rd_data_q;
	logic                            rd_vld_q;

	// result register
	logic                            out_valid_q;
	logic [lltd_pkg::STATUS_W-1:0]   out_status_q;
	logic [lltd_pkg::WORKER_W-1:0]   out_worker_q;
	logic [lltd_pkg::TAG_W-1:0]      out_tag_q;
	logic [lltd_pkg::LOAD_W-1:0]     out_load_q;

	// combinational
	logic                            s_acc;
	logic [lltd_pkg::DONE_W-1:0]     in_done;
	logic [lltd_pkg::TAG_W-1:0]      in_tag;
	logic [CmpW-1:0]                 n_act;
	logic [IdxW-1:0]                 start_idx;
	logic [IdxW-1:0]                 start_nxt;
	logic [IdxW-1:0]                 idx_nxt;
	logic                            in_done_bad;
	logic [IdxW-1:0]                 rd_addr;
	logic [COUNT_BITS-1:0]           cnt_rd;
	logic                            cmp_zero;
	logic                            cmp_better;
	logic                            scan_end;
	logic                            issue;
	logic                            out_free;
	logic                            fin;
	logic                            wr_en;
	logic [IdxW-1:0]                 wr_addr;
	logic [COUNT_BITS-1:0]           wr_data;
	logic [lltd_pkg::STATUS_W-1:0]   res_status;
	logic [lltd_pkg::WORKER_W-1:0]   res_worker;
	logic [lltd_pkg::TAG_W-1:0]      res_tag;
	logic [lltd_pkg::LOAD_W-1:0]     res_load;
	logic                            lim_hit;
	logic                            cnt_full;
	logic                            c_bad;

	assign s_tready  = (state_q == S_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign in_done   = s_tdata[lltd_pkg::DONE_W-1:0];
	assign in_tag    = s_tdata[lltd_pkg::DONE_W +: lltd_pkg::TAG_W];
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(lltd_pkg::M_DATA_W - lltd_pkg::WORKER_W - lltd_pkg::TAG_W
		- lltd_pkg::LOAD_W){1'b0}}, out_load_q, out_tag_q, out_worker_q};

	assign out_free = !out_valid_q || m_tready;
	assign cnt_rd   = rd_vld_q ? rd_data_q : '0;

	always_comb begin
		// workers in use, zero acts as one, clamped to the pool size
		if (wiu_q == '0) begin
			n_act = CmpW'(1);
		end else if (CmpW'(wiu_q) > CmpW'(MAX_WORKERS)) begin
			n_act = CmpW'(MAX_WORKERS);
		end else begin
			n_act = CmpW'(wiu_q);
		end

		// scan start, the round-robin pointer or else worker zero; a stale pointer falls back to worker zero
		if (rr_q && (CmpW'(ptr_q) < n_act)) begin
			start_idx = ptr_q;
		end else begin
			start_idx = '0;
		end
		start_nxt = ((CmpW'(start_idx) + CmpW'(1)) >= n_act) ? '0 : start_idx + 1'b1;
		idx_nxt   = ((CmpW'(idx_q) + CmpW'(1)) == n_act) ? '0 : idx_q + 1'b1;

		in_done_bad = (CmpW'(in_done) >= n_act);

		// shared compare unit
		cmp_zero   = cmp_vld_s1 && (cnt_rd == '0);
		cmp_better = cmp_vld_s1 && (!have_best_q || (cnt_rd < best_cnt_q));
		scan_end   = cmp_zero || (cmp_vld_s1 && (CmpW'(iss_q) == n_act));
		issue      = (CmpW'(iss_q) < n_act) && !cmp_zero;

		// memory read address
		unique case (state_q)
			S_IDLE:  rd_addr = IdxW'(in_done);
			S_CRD:   rd_addr = IdxW'(done_q);
			default: rd_addr = idx_q;
		endcase

		// dispatch decision
		lim_hit  = (limit_q != '0) && (LimW'(best_cnt_q) >= LimW'(limit_q));
		cnt_full = &best_cnt_q;
		// completion check
		c_bad    = done_bad_q || (cnt_rd == '0);

		fin        = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = best_q;
		wr_data    = best_cnt_q + 1'b1;
		res_status = lltd_pkg::ST_DISPATCHED;
		res_worker = lltd_pkg::WORKER_W'(best_q);
		res_tag    = tag_q;
		res_load   = lltd_pkg::LOAD_W'(best_cnt_q + 1'b1);

		unique case (state_q)
			S_CRD: begin
				fin        = out_free;
				res_worker = done_q;
				res_tag    = '0;
				wr_addr    = IdxW'(done_q);
				wr_data    = cnt_rd - 1'b1;
				if (c_bad) begin
					res_status = lltd_pkg::ST_DONE_ERR;
					res_load   = '0;
				end else begin
					res_status = lltd_pkg::ST_DONE_OK;
					res_load   = lltd_pkg::LOAD_W'(cnt_rd - 1'b1);
					wr_en      = out_free;
				end
			end
			S_DEC: begin
				fin = out_free;
				if (lim_hit) begin
					// every worker at or above the limit: retry, no counter changes
					res_status = lltd_pkg::ST_RETRY;
					res_load   = lltd_pkg::LOAD_W'(best_cnt_q);
				end else if (cnt_full) begin
					res_status = lltd_pkg::ST_FULL;
					res_load   = lltd_pkg::LOAD_W'(best_cnt_q);
				end else begin
					wr_en = out_free;
				end
			end
			default: begin
			end
		endcase
	end

	// counter memory with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q   <= lltd_pkg::WIU_RESET;
			limit_q <= '0;
			rr_q    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lltd_pkg::REG_WORKERS_IN_USE:   wiu_q   <= cfg_data[lltd_pkg::WIU_W-1:0];
				lltd_pkg::REG_DISPATCH_LIMIT:   limit_q <= cfg_data[lltd_pkg::LIMIT_W-1:0];
				lltd_pkg::REG_ROUND_ROBIN_MODE: rr_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			idx_q       <= '0;
			iss_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			have_best_q <= 1'b0;
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end

			// result register
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					cmp_vld_s1  <= 1'b0;
					have_best_q <= 1'b0;
					iss_q       <= '0;
					if (s_acc) begin
						if (s_tuser == lltd_pkg::CMD_COMPLETE) begin
							state_q <= S_CRD;
						end else begin
							state_q <= S_SCAN;
							idx_q   <= start_idx;
							if (rr_q) begin
								ptr_q <= start_nxt;
							end
						end
					end
				end
				S_CRD: begin
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (cmp_better) begin
						have_best_q <= 1'b1;
					end
					// no issue in the last compare cycle, so the stage empties
					cmp_vld_s1 <= issue;
					if (issue) begin
						cmp_idx_s1 <= idx_q;
						idx_q      <= idx_nxt;
						iss_q      <= iss_q + 1'b1;
					end
					if (scan_end) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (fin) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			tag_q      <= in_tag;
			done_q     <= in_done;
			done_bad_q <= in_done_bad;
		end
		if ((state_q == S_SCAN) && cmp_better) begin
			best_q     <= cmp_idx_s1;
			best_cnt_q <= cnt_rd;
		end
		if (fin) begin
			out_status_q <= res_status;
			out_worker_q <= res_worker;
			out_tag_q    <= res_tag;
			out_load_q   <= res_load;
		end
	end

endmodule
